// File: src/rsis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rsis_pkg;

  localparam int MAX_INTERVALS = 16;
  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
  localparam int SEQ_W = 64;
  localparam int CTX_W = 32;
  localparam int KEY_W = 16;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OTHER = 2'd2;

  typedef struct packed {
    logic load;
    logic analyze;
    logic commit;
  } rsis_cmd_t;

endpackage
`default_nettype wire

// File: src/rsis_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rsis_ctrl
  import rsis_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output rsis_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ANALYZE,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   accept;

  assign busy = busy_r;
  assign accept = start && !busy_r;

  assign cmd.load = accept;
  assign cmd.analyze = (state_r == S_ANALYZE);
  assign cmd.commit = (state_r == S_COMMIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_ANALYZE;
        end
      end
      S_ANALYZE: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (start) begin
          state_nxt = S_ANALYZE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r <= accept;
    end
  end

endmodule
`default_nettype wire

// File: src/rsis_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rsis_dp
  import rsis_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rsis_cmd_t           cmd,
  input  wire logic                in_req_type,
  input  wire logic [CTX_W-1:0]    in_context_id,
  input  wire logic [KEY_W-1:0]    in_key_set,
  input  wire logic [SEQ_W-1:0]    in_seq,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_overflow,
  output logic [CNT_W-1:0]         out_interval_total
);

  // request transfer
  logic             req_add_r;
  logic [CTX_W-1:0] req_ctx_r;
  logic [KEY_W-1:0] req_key_r;
  logic [SEQ_W-1:0] req_seq_r;

  // held set
  logic             ctx_valid_r;
  logic [CTX_W-1:0] held_ctx_r;
  logic [KEY_W-1:0] held_key_r;
  logic [CNT_W-1:0] count_r;
  logic [SEQ_W-1:0] first_r [MAX_INTERVALS];
  logic [SEQ_W-1:0] last_r  [MAX_INTERVALS];

  // analysis results
  logic                     ctx_hit_r;
  logic                     found_r;
  logic [MAX_INTERVALS-1:0] below_r;
  logic [MAX_INTERVALS-1:0] above_r;
  logic [SEQ_W-1:0]         last_above_r;
  logic [SEQ_W-1:0]         tail_first_r;
  logic [SEQ_W-1:0]         tail_last_r;
  logic                     below_tail_r;

  logic [MAX_INTERVALS-1:0] lane_in;
  logic [MAX_INTERVALS-1:0] lane_below;
  logic [MAX_INTERVALS-1:0] lane_above;
  logic [MAX_INTERVALS-1:0] lane_tail;
  logic [SEQ_W-1:0]         last_above;
  logic [SEQ_W-1:0]         tail_first;
  logic [SEQ_W-1:0]         tail_last;
  logic                     ctx_hit;

  // commit decode
  logic [MAX_INTERVALS-1:0] wr_first;
  logic [MAX_INTERVALS-1:0] wr_last;
  logic [SEQ_W-1:0]         first_val [MAX_INTERVALS];
  logic [SEQ_W-1:0]         last_val  [MAX_INTERVALS];
  logic                     set_ctx;
  logic [CNT_W-1:0]         count_nxt;
  logic [STATUS_W-1:0]      status_nxt;
  logic                     ovf_nxt;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic                     out_overflow_r;
  logic [CNT_W-1:0]         out_total_r;

  assign ctx_hit = ctx_valid_r && (held_ctx_r == req_ctx_r) && (held_key_r == req_key_r);

  always_comb begin
    last_above = '0;
    tail_first = '0;
    tail_last = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      logic live;
      live = (CNT_W'(i) < count_r);
      lane_in[i] = live && (req_seq_r >= first_r[i]) && (req_seq_r <= last_r[i]);
      lane_below[i] = live && (last_r[i] != '1) && ((last_r[i] + SEQ_W'(1)) == req_seq_r);
      lane_above[i] = live && (req_seq_r != '1) && ((req_seq_r + SEQ_W'(1)) == first_r[i]);
      lane_tail[i] = (CNT_W'(i + 1) == count_r);
      if (lane_above[i]) begin
        last_above = last_above | last_r[i];
      end
      if (lane_tail[i]) begin
        tail_first = tail_first | first_r[i];
        tail_last = tail_last | last_r[i];
      end
    end
  end

  always_comb begin
    set_ctx = 1'b0;
    count_nxt = count_r;
    status_nxt = ST_ABSENT;
    ovf_nxt = 1'b0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      wr_first[i] = 1'b0;
      wr_last[i] = 1'b0;
      first_val[i] = req_seq_r;
      last_val[i] = req_seq_r;
    end
    if (!ctx_hit_r) begin
      if (req_add_r) begin
        set_ctx = 1'b1;
        wr_first[0] = 1'b1;
        wr_last[0] = 1'b1;
        count_nxt = CNT_W'(1);
      end else begin
        status_nxt = ST_OTHER;
      end
    end else if (found_r) begin
      status_nxt = ST_PRESENT;
    end else if (req_add_r) begin
      if ((|below_r) && (|above_r)) begin
        // merge the two neighbors, tail entry fills the freed slot
        for (int i = 0; i < MAX_INTERVALS; i++) begin
          if (below_r[i]) begin
            wr_last[i] = 1'b1;
            last_val[i] = last_above_r;
          end
          if (above_r[i]) begin
            wr_first[i] = 1'b1;
            wr_last[i] = 1'b1;
            first_val[i] = tail_first_r;
            last_val[i] = below_tail_r ? last_above_r : tail_last_r;
          end
        end
        count_nxt = count_r - CNT_W'(1);
      end else if (|below_r) begin
        wr_last = below_r;
      end else if (|above_r) begin
        wr_first = above_r;
      end else if (count_r >= CNT_W'(MAX_INTERVALS)) begin
        ovf_nxt = 1'b1;
      end else begin
        for (int i = 0; i < MAX_INTERVALS; i++) begin
          if (CNT_W'(i) == count_r) begin
            wr_first[i] = 1'b1;
            wr_last[i] = 1'b1;
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_add_r <= in_req_type;
      req_ctx_r <= in_context_id;
      req_key_r <= in_key_set;
      req_seq_r <= in_seq;
    end
    if (cmd.analyze) begin
      ctx_hit_r <= ctx_hit;
      found_r <= |lane_in;
      below_r <= lane_below;
      above_r <= lane_above;
      last_above_r <= last_above;
      tail_first_r <= tail_first;
      tail_last_r <= tail_last;
      below_tail_r <= |(lane_below & lane_tail);
    end
    if (cmd.commit) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        if (wr_first[i]) begin
          first_r[i] <= first_val[i];
        end
        if (wr_last[i]) begin
          last_r[i] <= last_val[i];
        end
      end
      out_status_r <= status_nxt;
      out_overflow_r <= ovf_nxt;
      out_total_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_valid_r <= 1'b0;
      held_ctx_r <= '0;
      held_key_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        count_r <= count_nxt;
        if (set_ctx) begin
          ctx_valid_r <= 1'b1;
          held_ctx_r <= req_ctx_r;
          held_key_r <= req_key_r;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_overflow = out_overflow_r;
  assign out_interval_total = out_total_r;

endmodule
`default_nettype wire

// File: src/received_sequence_interval_set.sv
// channel   ports                                        transfer
// request   start, busy, in_req_type, in_context_id,      start && !busy
//           in_key_set, in_seq
// result    out_valid, out_status, out_overflow,         out_valid, one cycle
//           out_interval_total
//
// a request first compares seq against all held intervals in parallel, then
// writes the interval table and registers the result
// the result strobe is registered after the request and compare registers
// a request can load as the last commits, busy is high the cycle after a transfer
// reset is synchronous, active low; the interval table holds no reset value
// the receiver cannot stall, each result is shown for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none
module received_sequence_interval_set
  import rsis_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_req_type,
  input  wire logic [CTX_W-1:0]    in_context_id,
  input  wire logic [KEY_W-1:0]    in_key_set,
  input  wire logic [SEQ_W-1:0]    in_seq,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic                     out_overflow,
  output logic [CNT_W-1:0]         out_interval_total
);

  rsis_cmd_t cmd;

  rsis_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  rsis_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_context_id      (in_context_id),
    .in_key_set         (in_key_set),
    .in_seq             (in_seq),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_overflow       (out_overflow),
    .out_interval_total (out_interval_total)
  );

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rsis_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                overflow;
    logic [CNT_W-1:0]    total;
  } reply_t;

  class received_set_checker;
    bit                 ctx_valid;
    logic [CTX_W-1:0]   held_ctx;
    logic [KEY_W-1:0]   held_key;
    logic [SEQ_W-1:0]   first_seq [MAX_INTERVALS];
    logic [SEQ_W-1:0]   last_seq [MAX_INTERVALS];
    int unsigned        held_count;
    reply_t             expected_replies[$];
    int unsigned        failures;

    function new();
      ctx_valid = 0;
      held_ctx = '0;
      held_key = '0;
      held_count = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function void note_request(bit add, logic [CTX_W-1:0] ctx, logic [KEY_W-1:0] key,
                               logic [SEQ_W-1:0] seq);
      reply_t r;
      int below;
      int above;
      int n;
      bit hit;
      r.status = ST_ABSENT;
      r.overflow = 1'b0;
      n = held_count;
      below = -1;
      above = -1;
      hit = 0;
      if (!ctx_valid || ctx != held_ctx || key != held_key) begin
        if (!add) begin
          r.status = ST_OTHER;
        end else begin
          ctx_valid = 1;
          held_ctx = ctx;
          held_key = key;
          first_seq[0] = seq;
          last_seq[0] = seq;
          held_count = 1;
        end
      end else begin
        for (int i = 0; i < n; i++)
          if (seq >= first_seq[i] && seq <= last_seq[i]) hit = 1;
        if (hit) begin
          r.status = ST_PRESENT;
        end else if (add) begin
          for (int i = 0; i < n; i++) begin
            if (below < 0 && last_seq[i] != '1 && last_seq[i] + 64'd1 == seq) below = i;
            if (above < 0 && seq != '1 && seq + 64'd1 == first_seq[i]) above = i;
          end
          if (below >= 0 && above >= 0 && below != above) begin
            last_seq[below] = last_seq[above];
            first_seq[above] = first_seq[n-1];
            last_seq[above] = last_seq[n-1];
            held_count = n - 1;
          end else if (below >= 0) begin
            last_seq[below] = seq;
          end else if (above >= 0) begin
            first_seq[above] = seq;
          end else if (n >= MAX_INTERVALS) begin
            r.overflow = 1'b1;
          end else begin
            first_seq[n] = seq;
            last_seq[n] = seq;
            held_count = n + 1;
          end
        end
      end
      r.total = CNT_W'(held_count);
      expected_replies.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic overflow,
                               logic [CNT_W-1:0] total);
      reply_t e;
      if (expected_replies.size() == 0) begin
        $error("result with no request pending");
        failures++;
      end else begin
        e = expected_replies.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status);
          failures++;
        end
        if (overflow !== e.overflow) begin
          $error("overflow: expected %0d actual %0d", e.overflow, overflow);
          failures++;
        end
        if (total !== e.total) begin
          $error("interval_total: expected %0d actual %0d", e.total, total);
          failures++;
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_req_type = 1'b0;
  logic [CTX_W-1:0]    in_context_id = '0;
  logic [KEY_W-1:0]    in_key_set = '0;
  logic [SEQ_W-1:0]    in_seq = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_overflow;
  logic [CNT_W-1:0]    out_interval_total;

  localparam int unsigned STALL_LIMIT = 4000;

  received_set_checker sb = new();
  int unsigned stall_cycles = 0;

  received_sequence_interval_set i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_context_id      (in_context_id),
    .in_key_set         (in_key_set),
    .in_seq             (in_seq),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_overflow       (out_overflow),
    .out_interval_total (out_interval_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_request(in_req_type, in_context_id, in_key_set, in_seq);
    if (rst_n && out_valid)
      sb.check_result(out_status, out_overflow, out_interval_total);
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("received_sequence_interval_set test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic idle_gap(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send(input bit add, input logic [CTX_W-1:0] ctx, input logic [KEY_W-1:0] key,
                      input logic [SEQ_W-1:0] seq, input int unsigned idle_pct);
    idle_gap(idle_pct);
    start <= 1'b1;
    in_req_type <= add;
    in_context_id <= ctx;
    in_key_set <= key;
    in_seq <= seq;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // episodes of mostly well-formed traffic on a few reused contexts
  task automatic run_episodes(input int unsigned items, input int unsigned idle_pct);
    logic [CTX_W-1:0] ctx_pool [4];
    logic [KEY_W-1:0] key_pool [4];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] seq;
    int unsigned sent;
    int unsigned c;
    int unsigned len;
    int unsigned span;
    int unsigned roll;
    bit sparse;
    sent = 0;
    for (int i = 0; i < 4; i++) begin
      ctx_pool[i] = $urandom;
      key_pool[i] = KEY_W'($urandom);
    end
    while (sent < items) begin
      c = $urandom_range(0, 3);
      base = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: base = '1 - SEQ_W'($urandom_range(0, 40));
        1: base = SEQ_W'($urandom_range(0, 8));
        default: ;
      endcase
      sparse = 1'($urandom_range(0, 1));
      span = $urandom_range(8, 40);
      len = $urandom_range(20, 60);
      for (int j = 0; j < len && sent < items; j++) begin
        roll = $urandom_range(0, 99);
        if (j > 0 && roll < 6) begin
          send($urandom_range(0, 3) == 0, $urandom, KEY_W'($urandom), {$urandom, $urandom},
               idle_pct);
        end else if (j > 0 && roll < 9) begin
          send(1'b0, ctx_pool[c], key_pool[c] ^ (16'd1 << $urandom_range(0, KEY_W - 1)),
               base + SEQ_W'($urandom_range(0, span)), idle_pct);
        end else begin
          if (sparse && j < len / 2)
            seq = base + SEQ_W'(2 * $urandom_range(0, span));
          else
            seq = base + SEQ_W'($urandom_range(0, 2 * span));
          send(j == 0 || roll < 70, ctx_pool[c], key_pool[c], seq, idle_pct);
        end
        sent++;
      end
    end
  endtask

  initial begin
    logic [CTX_W-1:0] ctx_a;
    logic [KEY_W-1:0] key_a;
    ctx_a = '1;
    key_a = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(1'b0, '0, '0, '0, 10);
    send(1'b1, ctx_a, key_a, '1, 10);
    send(1'b0, ctx_a, key_a, '1, 10);
    send(1'b1, ctx_a, key_a, '0, 10);
    send(1'b1, ctx_a, key_a, '1 - 64'd1, 10);
    send(1'b0, ctx_a, 16'hFFFE, 64'd5, 10);
    send(1'b1, ctx_a, key_a, 64'd2, 10);
    send(1'b1, ctx_a, key_a, 64'd1, 10);
    send(1'b1, ctx_a, key_a, 64'd3, 10);
    for (int k = 0; k < 14; k++)
      send(1'b1, ctx_a, key_a, 64'd10 + 64'(2 * k), 10);
    send(1'b1, ctx_a, key_a, 64'd100, 10);
    send(1'b1, ctx_a, key_a, 64'd11, 10);
    send(1'b1, '0, '0, 64'h5555_5555_5555_5555, 10);
    drain();

    run_episodes(520, 10);
    drain();
    run_episodes(520, 86);
    drain();
    run_episodes(510, 0);
    drain();
    repeat (4) @(posedge clk);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("received_sequence_interval_set test passed");
    end else begin
      $display("received_sequence_interval_set test failed");
    end
    $finish;
  end

endmodule
